### src/hlls_pkg.sv
// Types and constants for the hexapod leg length solver.
package hlls_pkg;

    localparam int NUM_LEGS   = 6;
    localparam int MAX_CORDIC = 30;
    localparam int SQ_W       = 46;    // squared leg length
    localparam int RT_W       = SQ_W / 2;
    localparam int RM_W       = RT_W + 2;
    localparam int D_W        = 22;    // per-axis distance magnitude

    localparam logic signed [34:0] ANGLE_SCALE     = 35'sd107374;
    localparam logic signed [34:0] HALF_PI_Q30     = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30          = 35'sd3373259426;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [56:0] Q30_ONE_HALF    = 57'sd536870912;
    localparam logic [RT_W:0]      LEN_MAX         = 24'd2000000;

    localparam logic signed [31:0] ATAN_Q30 [0:MAX_CORDIC-1] = '{
        32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
        32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
        32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
        32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
        32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
        32'sd1023,      32'sd511,       32'sd255,       32'sd127,
        32'sd63,        32'sd31,        32'sd15,        32'sd7,
        32'sd3,         32'sd1
    };

    localparam logic signed [19:0] PLAT_JOINT [0:NUM_LEGS-1][0:2] = '{
        '{ 20'sd242334,   20'sd69222,  -20'sd40000},
        '{ 20'sd181115,  20'sd175257,  -20'sd40000},
        '{-20'sd181115,  20'sd175257,  -20'sd40000},
        '{-20'sd242334,   20'sd69222,  -20'sd40000},
        '{ -20'sd61219, -20'sd244478,  -20'sd40000},
        '{  20'sd61219, -20'sd244478,  -20'sd40000}
    };

    localparam logic signed [19:0] BASE_JOINT [0:NUM_LEGS-1][0:2] = '{
        '{ 20'sd358245, -20'sd100280,  20'sd40000},
        '{  20'sd92278,  20'sd360390,  20'sd40000},
        '{ -20'sd92278,  20'sd360390,  20'sd40000},
        '{-20'sd358245, -20'sd100280,  20'sd40000},
        '{-20'sd265968, -20'sd260110,  20'sd40000},
        '{ 20'sd265968, -20'sd260110,  20'sd40000}
    };

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_pose;

    typedef struct packed {
        logic [20:0] leg_length_0;
        logic [20:0] leg_length_1;
        logic [20:0] leg_length_2;
        logic [20:0] leg_length_3;
        logic [20:0] leg_length_4;
        logic [20:0] leg_length_5;
    } t_legs;

    // Q30 product, floored
    function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b);
        return 34'(p >>> 30);
    endfunction

endpackage

### src/hexapod_leg_length_solver.sv
// Hexapod leg length solver: pose in, six leg lengths out, fully pipelined.
// Stages: angle fold, one CORDIC stage per iteration, rotation matrix, joint
// transform, one square-root stage per bit.
// Throughput: one pose per cycle; the whole pipe holds while the output
// transaction is stalled.
// Reset (i_rst_n low, synchronous) clears all stage valid bits.
module hexapod_leg_length_solver
    import hlls_pkg::*;
#(
    parameter int SINCOS_ITERATIONS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_pose i_pose,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_legs o_result
);

    localparam int N    = SINCOS_ITERATIONS;
    localparam int LAT  = N + 32;
    localparam int T_D  = N + 5;   // translation delay slots up to the transform

    logic ce;
    logic r_vld [0:LAT-1];

    // stage A / CORDIC
    logic signed [15:0] w_ang [0:2];
    logic signed [34:0] w_zraw [0:2];
    logic signed [33:0] n_z0 [0:2];
    logic               n_neg0 [0:2];
    logic signed [33:0] r_cx [0:N][0:2];
    logic signed [33:0] r_cy [0:N][0:2];
    logic signed [33:0] r_cz [0:N][0:2];
    logic               r_cneg [0:N][0:2];
    logic signed [33:0] n_cx [1:N][0:2];
    logic signed [33:0] n_cy [1:N][0:2];
    logic signed [33:0] n_cz [1:N][0:2];
    logic signed [19:0] r_t [0:T_D-1][0:2];

    // sin/cos and rotation matrix
    logic signed [33:0] r_sin [0:2];
    logic signed [33:0] r_cos [0:2];
    logic signed [33:0] r_cbcc, r_cbsc, r_sasb, r_casc, r_cacc;
    logic signed [33:0] r_sacb, r_casb, r_sasc, r_sacc, r_cacb;
    logic signed [33:0] r_sb1, r_sc1, r_cc1;
    logic signed [34:0] r_rot [0:2][0:2];

    // joint transform and squared length
    logic signed [55:0] r_prod [0:NUM_LEGS-1][0:2][0:2];
    logic signed [56:0] w_acc [0:NUM_LEGS-1][0:2];
    logic signed [31:0] w_d [0:NUM_LEGS-1][0:2];
    logic [D_W-1:0]     r_d [0:NUM_LEGS-1][0:2];
    logic [2*D_W-1:0]   r_sq [0:NUM_LEGS-1][0:2];

    // square root
    logic [SQ_W-1:0]    r_sv [0:RT_W-1][0:NUM_LEGS-1];
    logic [RT_W-1:0]    r_sr [0:RT_W][0:NUM_LEGS-1];
    logic [RM_W-1:0]    r_srem [0:RT_W][0:NUM_LEGS-1];
    logic [RT_W-1:0]    n_sr [1:RT_W][0:NUM_LEGS-1];
    logic [RM_W-1:0]    n_srem [1:RT_W][0:NUM_LEGS-1];
    logic [RM_W+1:0]    w_rr [1:RT_W][0:NUM_LEGS-1];
    logic [RM_W+1:0]    w_tt [1:RT_W][0:NUM_LEGS-1];
    logic [RT_W:0]      w_len [0:NUM_LEGS-1];
    logic [20:0]        r_len [0:NUM_LEGS-1];

    assign ce          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !ce;
    assign o_out_valid = r_vld[LAT-1];

    assign w_ang[0] = i_pose.roll_angle;
    assign w_ang[1] = i_pose.pitch_angle;
    assign w_ang[2] = i_pose.yaw_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // fold angle into +-pi/2, remember to negate sin and cos
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_zraw[a] = 35'(w_ang[a]) * ANGLE_SCALE;
            if (w_zraw[a] > HALF_PI_Q30) begin
                n_z0[a]   = 34'(w_zraw[a] - PI_Q30);
                n_neg0[a] = 1'b1;
            end else if (w_zraw[a] < -HALF_PI_Q30) begin
                n_z0[a]   = 34'(w_zraw[a] + PI_Q30);
                n_neg0[a] = 1'b1;
            end else begin
                n_z0[a]   = 34'(w_zraw[a]);
                n_neg0[a] = 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int a = 0; a < 3; a++) begin
                if (r_cz[i][a] >= 0) begin
                    n_cx[i+1][a] = r_cx[i][a] - (r_cy[i][a] >>> i);
                    n_cy[i+1][a] = r_cy[i][a] + (r_cx[i][a] >>> i);
                    n_cz[i+1][a] = r_cz[i][a] - 34'(ATAN_Q30[i]);
                end else begin
                    n_cx[i+1][a] = r_cx[i][a] + (r_cy[i][a] >>> i);
                    n_cy[i+1][a] = r_cy[i][a] - (r_cx[i][a] >>> i);
                    n_cz[i+1][a] = r_cz[i][a] + 34'(ATAN_Q30[i]);
                end
            end
        end
    end

    // rotated joint, rounded half up, plus translation minus base joint
    always_comb begin
        for (int l = 0; l < NUM_LEGS; l++) begin
            for (int j = 0; j < 3; j++) begin
                w_acc[l][j] = 57'(r_prod[l][j][0]) + 57'(r_prod[l][j][1])
                            + 57'(r_prod[l][j][2]);
                w_d[l][j] = 32'((w_acc[l][j] + Q30_ONE_HALF) >>> 30)
                          + 32'(r_t[T_D-1][j]) - 32'(BASE_JOINT[l][j]);
            end
        end
    end

    // restoring square root, one result bit per stage
    always_comb begin
        for (int s = 0; s < RT_W; s++) begin
            for (int l = 0; l < NUM_LEGS; l++) begin
                w_rr[s+1][l] = {r_srem[s][l], r_sv[s][l][SQ_W-1-2*s -: 2]};
                w_tt[s+1][l] = (RM_W+2)'({r_sr[s][l], 2'b01});
                if (w_rr[s+1][l] >= w_tt[s+1][l]) begin
                    n_srem[s+1][l] = RM_W'(w_rr[s+1][l] - w_tt[s+1][l]);
                    n_sr[s+1][l]   = {r_sr[s][l][RT_W-2:0], 1'b1};
                end else begin
                    n_srem[s+1][l] = RM_W'(w_rr[s+1][l]);
                    n_sr[s+1][l]   = {r_sr[s][l][RT_W-2:0], 1'b0};
                end
            end
        end
        for (int l = 0; l < NUM_LEGS; l++) begin
            w_len[l] = (RT_W+1)'(r_sr[RT_W][l])
                     + (RT_W+1)'(r_srem[RT_W][l] > RM_W'(r_sr[RT_W][l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // stage A
            for (int a = 0; a < 3; a++) begin
                r_cx[0][a]   <= CORDIC_GAIN_INV;
                r_cy[0][a]   <= '0;
                r_cz[0][a]   <= n_z0[a];
                r_cneg[0][a] <= n_neg0[a];
            end
            r_t[0][0] <= i_pose.pos_x;
            r_t[0][1] <= i_pose.pos_y;
            r_t[0][2] <= i_pose.pos_z;
            for (int k = 1; k < T_D; k++) begin
                for (int j = 0; j < 3; j++) r_t[k][j] <= r_t[k-1][j];
            end

            // CORDIC stages
            for (int i = 1; i <= N; i++) begin
                for (int a = 0; a < 3; a++) begin
                    r_cx[i][a]   <= n_cx[i][a];
                    r_cy[i][a]   <= n_cy[i][a];
                    r_cz[i][a]   <= n_cz[i][a];
                    r_cneg[i][a] <= r_cneg[i-1][a];
                end
            end

            for (int a = 0; a < 3; a++) begin
                r_sin[a] <= r_cneg[N][a] ? -r_cy[N][a] : r_cy[N][a];
                r_cos[a] <= r_cneg[N][a] ? -r_cx[N][a] : r_cx[N][a];
            end

            // pairwise products (a = roll, b = pitch, c = yaw)
            r_cbcc <= qmul(r_cos[1], r_cos[2]);
            r_cbsc <= qmul(r_cos[1], r_sin[2]);
            r_sasb <= qmul(r_sin[0], r_sin[1]);
            r_casc <= qmul(r_cos[0], r_sin[2]);
            r_cacc <= qmul(r_cos[0], r_cos[2]);
            r_sacb <= qmul(r_sin[0], r_cos[1]);
            r_casb <= qmul(r_cos[0], r_sin[1]);
            r_sasc <= qmul(r_sin[0], r_sin[2]);
            r_sacc <= qmul(r_sin[0], r_cos[2]);
            r_cacb <= qmul(r_cos[0], r_cos[1]);
            r_sb1  <= r_sin[1];
            r_sc1  <= r_sin[2];
            r_cc1  <= r_cos[2];

            // R = Rx * Ry * Rz
            r_rot[0][0] <= 35'(r_cbcc);
            r_rot[0][1] <= -35'(r_cbsc);
            r_rot[0][2] <= 35'(r_sb1);
            r_rot[1][0] <= 35'(qmul(r_sasb, r_cc1)) + 35'(r_casc);
            r_rot[1][1] <= -35'(qmul(r_sasb, r_sc1)) + 35'(r_cacc);
            r_rot[1][2] <= -35'(r_sacb);
            r_rot[2][0] <= -35'(qmul(r_casb, r_cc1)) + 35'(r_sasc);
            r_rot[2][1] <= 35'(qmul(r_casb, r_sc1)) + 35'(r_sacc);
            r_rot[2][2] <= 35'(r_cacb);

            for (int l = 0; l < NUM_LEGS; l++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_prod[l][j][k] <= 56'(r_rot[j][k]) * 56'(PLAT_JOINT[l][k]);
                    end
                    r_d[l][j]  <= D_W'(w_d[l][j] < 0 ? -w_d[l][j] : w_d[l][j]);
                    r_sq[l][j] <= (2*D_W)'(r_d[l][j]) * (2*D_W)'(r_d[l][j]);
                end
                r_sv[0][l]   <= SQ_W'(r_sq[l][0]) + SQ_W'(r_sq[l][1])
                              + SQ_W'(r_sq[l][2]);
                r_sr[0][l]   <= '0;
                r_srem[0][l] <= '0;
                for (int s = 1; s < RT_W; s++) begin
                    r_sv[s][l] <= r_sv[s-1][l];
                end
                for (int s = 1; s <= RT_W; s++) begin
                    r_sr[s][l]   <= n_sr[s][l];
                    r_srem[s][l] <= n_srem[s][l];
                end
                r_len[l] <= (w_len[l] > LEN_MAX) ? 21'(LEN_MAX) : 21'(w_len[l]);
            end
        end
    end

    assign o_result.leg_length_0 = r_len[0];
    assign o_result.leg_length_1 = r_len[1];
    assign o_result.leg_length_2 = r_len[2];
    assign o_result.leg_length_3 = r_len[3];
    assign o_result.leg_length_4 = r_len[4];
    assign o_result.leg_length_5 = r_len[5];

endmodule

### bench/hlls_leg_checker.sv
// Checker for the hexapod leg length solver: predicts leg lengths per pose and compares.
`timescale 1ns / 100ps
module hlls_leg_checker
    import hlls_pkg::*;
#(
    parameter int SINCOS_ITERATIONS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_stall,
    input  t_pose i_pose,
    input  logic  i_out_valid,
    input  logic  i_out_stall,
    input  t_legs i_result,
    output int    o_errors,
    output int    o_pending,
    output int    o_checked
);

    t_legs expected_legs[$];

    function automatic void pose_sincos(input logic signed [15:0] ang,
                                        output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z    = longint'(ang) * longint'(ANGLE_SCALE);
        x    = longint'(CORDIC_GAIN_INV);
        y    = 0;
        flip = 0;
        if (z > longint'(HALF_PI_Q30)) begin
            z -= longint'(PI_Q30);
            flip = 1;
        end else if (z < -longint'(HALF_PI_Q30)) begin
            z += longint'(PI_Q30);
            flip = 1;
        end
        for (int i = 0; i < SINCOS_ITERATIONS && i < MAX_CORDIC; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_Q30[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // bitwise integer square root, rounded to nearest
    function automatic longint unsigned rounded_root(input longint unsigned v);
        longint unsigned rem, root, bitv;
        rem  = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        if (v - root * root > root) root++;
        return root;
    endfunction

    function automatic t_legs solve_legs(input t_pose p);
        longint          tr[3], rot[3][3], acc, d;
        longint          sa, ca, sb, cb, sc, cc;
        longint unsigned sq, len;
        logic [20:0]     lens[NUM_LEGS];
        t_legs           res;
        tr[0] = longint'(p.pos_x);
        tr[1] = longint'(p.pos_y);
        tr[2] = longint'(p.pos_z);
        pose_sincos(p.roll_angle, sa, ca);
        pose_sincos(p.pitch_angle, sb, cb);
        pose_sincos(p.yaw_angle, sc, cc);
        rot[0][0] = q30_mul(cb, cc);
        rot[0][1] = -q30_mul(cb, sc);
        rot[0][2] = sb;
        rot[1][0] = q30_mul(q30_mul(sa, sb), cc) + q30_mul(ca, sc);
        rot[1][1] = -q30_mul(q30_mul(sa, sb), sc) + q30_mul(ca, cc);
        rot[1][2] = -q30_mul(sa, cb);
        rot[2][0] = -q30_mul(q30_mul(ca, sb), cc) + q30_mul(sa, sc);
        rot[2][1] = q30_mul(q30_mul(ca, sb), sc) + q30_mul(sa, cc);
        rot[2][2] = q30_mul(ca, cb);
        for (int i = 0; i < NUM_LEGS; i++) begin
            sq = 0;
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += rot[j][k] * longint'(PLAT_JOINT[i][k]);
                d = ((acc + 536870912) >>> 30) + tr[j] - longint'(BASE_JOINT[i][j]);
                if (d < 0) d = -d;
                sq += longint'(d) * longint'(d);
            end
            len = rounded_root(sq);
            if (len > 2000000) len = 2000000;
            lens[i] = len[20:0];
        end
        res.leg_length_0 = lens[0];
        res.leg_length_1 = lens[1];
        res.leg_length_2 = lens[2];
        res.leg_length_3 = lens[3];
        res.leg_length_4 = lens[4];
        res.leg_length_5 = lens[5];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_legs want;
        if (!i_rst_n) begin
            expected_legs.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_checked <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_legs.push_back(solve_legs(i_pose));
            if (i_out_valid && !i_out_stall) begin
                if (expected_legs.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result transaction: %h", i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_legs.pop_front();
                    o_checked <= o_checked + 1;
                    if (want !== i_result) begin
                        if (o_errors < 10)
                            $display({"leg mismatch #%0d: exp %0d %0d %0d %0d %0d %0d",
                                      " got %0d %0d %0d %0d %0d %0d"},
                                o_checked, want.leg_length_0, want.leg_length_1,
                                want.leg_length_2, want.leg_length_3, want.leg_length_4,
                                want.leg_length_5, i_result.leg_length_0,
                                i_result.leg_length_1, i_result.leg_length_2,
                                i_result.leg_length_3, i_result.leg_length_4,
                                i_result.leg_length_5);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_legs.size();
        end
    end

endmodule

### bench/tb_top.sv
// Testbench top for the hexapod leg length solver: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
    import hlls_pkg::*;

    localparam int  SINCOS_ITERATIONS = 16;
    localparam int  LATENCY     = SINCOS_ITERATIONS + 32;
    localparam int  CYCLE_LIMIT = 400000;

    logic  i_clk = 0;
    logic  i_rst_n = 0;
    logic  i_in_valid = 0;
    logic  o_in_stall;
    t_pose i_pose = '0;
    logic  o_out_valid;
    logic  i_out_stall = 0;
    t_legs o_result;

    int    errors, pending, checked;
    int    idle_pct = 0, stall_pct = 0;
    int    cycles = 0;
    int    sent = 0;
    logic  pose_taken = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    hexapod_leg_length_solver #(
        .SINCOS_ITERATIONS(SINCOS_ITERATIONS)
    ) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_pose(i_pose),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_result(o_result)
    );

    hlls_leg_checker #(
        .SINCOS_ITERATIONS(SINCOS_ITERATIONS)
    ) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_pose(i_pose),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_result(o_result),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        pose_taken <= i_in_valid && !o_in_stall;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);

    task automatic send_pose(input t_pose p);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_in_valid = 1;
        i_pose     = p;
        @(negedge i_clk);
        while (!pose_taken) @(negedge i_clk);
        sent++;
    endtask

    function automatic t_pose make_pose(input int x, input int y, input int z,
                                        input int a, input int b, input int c);
        t_pose p;
        p.pos_x       = 20'(x);
        p.pos_y       = 20'(y);
        p.pos_z       = 20'(z);
        p.roll_angle  = 16'(a);
        p.pitch_angle = 16'(b);
        p.yaw_angle   = 16'(c);
        return p;
    endfunction

    function automatic int rand_pos();
        if ($urandom_range(9) == 0) return int'($urandom_range(20'hFFFFF)) - 524288;
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 500000 : -500000;
        return int'($urandom_range(1000000)) - 500000;
    endfunction

    function automatic int rand_angle();
        if ($urandom_range(9) == 0) return int'($urandom_range(16'hFFFF)) - 32768;
        if ($urandom_range(9) == 0) return int'($urandom_range(15720, 15700)) *
                                           ($urandom_range(1) ? 1 : -1);
        return int'($urandom_range(62832)) - 31416;
    endfunction

    initial begin
        int phase_items;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed poses: neutral, translation and angle extremes, pi/2 fold edges
        send_pose(make_pose(0, 0, 0, 0, 0, 0));
        send_pose(make_pose(500000, 500000, 500000, 0, 0, 0));
        send_pose(make_pose(-500000, -500000, -500000, 0, 0, 0));
        send_pose(make_pose(-524288, -524288, -524288, 0, 0, 0));
        send_pose(make_pose(524287, 524287, 524287, 0, 0, 0));
        send_pose(make_pose(524287, -524288, 524287, 31416, -31416, 31416));
        send_pose(make_pose(0, 0, 0, 31416, 31416, 31416));
        send_pose(make_pose(0, 0, 0, -31416, -31416, -31416));
        send_pose(make_pose(0, 0, 0, 32767, -32768, 32767));
        send_pose(make_pose(0, 0, 0, -32768, 32767, -32768));
        send_pose(make_pose(0, 0, 0, 15707, 15708, -15708));
        send_pose(make_pose(0, 0, 0, -15707, 15709, -15709));
        send_pose(make_pose(100000, 0, 200000, 15708, -15707, 0));
        send_pose(make_pose(0, 300000, -200000, 5000, -7000, 12000));
        send_pose(make_pose(-524288, 524287, -524288, -32768, -32768, -32768));
        send_pose(make_pose(1, -1, 1, 1, -1, 1));

        phase_items = 425;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            for (int n = 0; n < phase_items; n++)
                send_pose(make_pose(rand_pos(), rand_pos(), rand_pos(),
                                    rand_angle(), rand_angle(), rand_angle()));
        end
        i_in_valid = 0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);

        $display("%0d poses sent, %0d leg sets checked, %0d mismatches", sent, checked, errors);
        $display("covered: fold edges, full-range fields, idle and stall phases");
        if (errors == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### hexapod_leg_length_solver.f
src/hlls_pkg.sv
src/hexapod_leg_length_solver.sv
bench/hlls_leg_checker.sv
bench/tb_top.sv
